// File: src/pre_pkg.sv
// Shared constants, types and codes for the palindrome radius engine.
package pre_pkg;

    localparam int MAX_SYMBOLS = 1024;
    localparam int STR_LEN     = 2 * MAX_SYMBOLS + 2;
    localparam int POS_W       = $clog2(STR_LEN + 2);
    localparam int EXT_W       = POS_W + 1;
    localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_AW      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SYM_W       = 30;
    localparam int FIELD_W     = 12;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [EXT_W-1:0]   t_ext;
    typedef logic [LEN_W-1:0]   t_len;

    typedef enum logic [1:0] {
        K_END,
        K_SENT,
        K_SEP,
        K_DATA
    } t_word_kind;

    typedef struct packed {
        t_word_kind       kind;
        logic [SYM_W-1:0] sym;
    } t_word;

    typedef struct packed {
        logic              we;
        logic [SYM_AW-1:0] addr;
        logic [SYM_W-1:0]  sym;
    } t_load;

endpackage

// File: src/pre_word_cmp.sv
// Shared word compare unit: tagged words match on equal kind, and data words also need equal data.
module pre_word_cmp (
    input  pre_pkg::t_word i_left,
    input  pre_pkg::t_word i_right,
    output logic           o_equal
);

    always_comb begin
        o_equal = (i_left.kind == i_right.kind) &&
                  ((i_left.kind != pre_pkg::K_DATA) || (i_left.sym == i_right.sym));
    end

endmodule

// File: src/pre_core.sv
// Manacher sequencer with symbol and radius memories around one compare unit.
module pre_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  pre_pkg::t_len   i_len,
    input  pre_pkg::t_load  i_load,
    input  pre_pkg::t_pos   i_host_addr,
    output pre_pkg::t_pos   o_rad_q,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_MIN,
        S_EXP,
        S_CMP,
        S_WRITE
    } t_state;

    t_state              r_state, n_state;
    pre_pkg::t_pos       r_i, n_i;
    pre_pkg::t_pos       r_c, n_c;
    pre_pkg::t_ext       r_reach, n_reach;
    pre_pkg::t_ext       r_r, n_r;
    logic                r_mirror_zero, n_mirror_zero;
    pre_pkg::t_word_kind r_kind_l, n_kind_l;
    pre_pkg::t_word_kind r_kind_r, n_kind_r;

    logic [pre_pkg::SYM_W-1:0] r_sym_mem [0:pre_pkg::MAX_SYMBOLS-1];
    logic [pre_pkg::SYM_W-1:0] r_sym_q_l, r_sym_q_r;
    pre_pkg::t_pos             r_rad_mem [0:pre_pkg::STR_LEN];
    pre_pkg::t_pos             r_rad_q_a, r_rad_q_b;

    pre_pkg::t_ext             n_pos, i_ext, c_ext, mirror, idx_l, idx_r;
    pre_pkg::t_ext             a_val, b_val, sum;
    pre_pkg::t_word_kind       kind_l, kind_r;
    logic [pre_pkg::SYM_AW-1:0] addr_l, addr_r;
    pre_pkg::t_pos             rad_a_addr;
    pre_pkg::t_word            word_l, word_r;
    logic                      equal;

    function automatic pre_pkg::t_word_kind classify(pre_pkg::t_ext idx, pre_pkg::t_ext npos);
        pre_pkg::t_word_kind k;
        if (idx == '0 || idx > npos) begin
            k = pre_pkg::K_END;
        end else if (idx == pre_pkg::t_ext'(1)) begin
            k = pre_pkg::K_SENT;
        end else if (!idx[0]) begin
            k = pre_pkg::K_SEP;
        end else begin
            k = pre_pkg::K_DATA;
        end
        return k;
    endfunction

    function automatic logic [pre_pkg::SYM_AW-1:0] sym_addr(pre_pkg::t_ext idx);
        pre_pkg::t_ext tmp;
        tmp = (idx - pre_pkg::t_ext'(3)) >> 1;
        return tmp[pre_pkg::SYM_AW-1:0];
    endfunction

    pre_word_cmp u_cmp (
        .i_left  (word_l),
        .i_right (word_r),
        .o_equal (equal)
    );

    always_comb begin
        n_pos  = (pre_pkg::t_ext'(i_len) << 1) + pre_pkg::t_ext'(2);
        i_ext  = pre_pkg::t_ext'(r_i);
        c_ext  = pre_pkg::t_ext'(r_c);
        mirror = (c_ext << 1) - i_ext;
        idx_l  = i_ext - r_r;
        idx_r  = i_ext + r_r;
        kind_l = classify(idx_l, n_pos);
        kind_r = classify(idx_r, n_pos);
        addr_l = (kind_l == pre_pkg::K_DATA) ? sym_addr(idx_l) : '0;
        addr_r = (kind_r == pre_pkg::K_DATA) ? sym_addr(idx_r) : '0;

        if (r_state == S_POS && mirror <= pre_pkg::t_ext'(pre_pkg::STR_LEN)) begin
            rad_a_addr = mirror[pre_pkg::POS_W-1:0];
        end else begin
            rad_a_addr = i_host_addr;
        end

        word_l.kind = r_kind_l;
        word_l.sym  = r_sym_q_l;
        word_r.kind = r_kind_r;
        word_r.sym  = r_sym_q_r;

        // mirror at index 0 reads as zero radius
        a_val = r_mirror_zero ? '0 : pre_pkg::t_ext'(r_rad_q_a);
        b_val = pre_pkg::t_ext'(r_rad_q_b) - (i_ext - c_ext);
        sum   = r_r + i_ext;
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_c           = r_c;
        n_reach       = r_reach;
        n_r           = r_r;
        n_mirror_zero = r_mirror_zero;
        n_kind_l      = r_kind_l;
        n_kind_r      = r_kind_r;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_i     = pre_pkg::t_pos'(1);
                    n_c     = '0;
                    n_reach = '0;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (i_ext > n_pos) begin
                    n_state = S_IDLE;
                end else if (i_ext < r_reach) begin
                    n_mirror_zero = (mirror == '0);
                    n_state       = S_MIN;
                end else begin
                    n_r     = pre_pkg::t_ext'(1);
                    n_state = S_EXP;
                end
            end
            S_MIN: begin
                n_r     = (a_val < b_val) ? a_val : b_val;
                n_state = S_EXP;
            end
            S_EXP: begin
                if ((r_r < i_ext + pre_pkg::t_ext'(1)) && (r_r <= n_pos)) begin
                    n_kind_l = kind_l;
                    n_kind_r = kind_r;
                    n_state  = S_CMP;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_CMP: begin
                if (equal) begin
                    n_r     = r_r + pre_pkg::t_ext'(1);
                    n_state = S_EXP;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (sum > r_reach) begin
                    n_reach = sum;
                    n_c     = r_i;
                end
                n_i     = r_i + pre_pkg::t_pos'(1);
                n_state = S_POS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i           <= n_i;
        r_c           <= n_c;
        r_reach       <= n_reach;
        r_r           <= n_r;
        r_mirror_zero <= n_mirror_zero;
        r_kind_l      <= n_kind_l;
        r_kind_r      <= n_kind_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we) begin
            r_sym_mem[i_load.addr] <= i_load.sym;
        end
        r_sym_q_l <= r_sym_mem[addr_l];
        r_sym_q_r <= r_sym_mem[addr_r];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_rad_mem[r_i] <= r_r[pre_pkg::POS_W-1:0];
        end
        r_rad_q_a <= r_rad_mem[rad_a_addr];
        r_rad_q_b <= r_rad_mem[r_c];
    end

    assign o_rad_q = r_rad_q_a;
    assign o_busy  = (r_state != S_IDLE);

endmodule

// File: src/palindrome_radius_engine.sv
// Top level: command port, sequence length and phase, read result register.
// Load word: produces no result. A load with last starts the radius pass, during which
// busy is high and the sequencer steps one compare at a time through two memory reads.
// Read word: result strobe in the cycle after acceptance, one read per cycle when idle.
// Synchronous active-low reset clears control and phase; stores hold no reset value.
module palindrome_radius_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [pre_pkg::SYM_W-1:0]  i_symbol,
    input  logic                       i_last,
    input  logic [11:0]                i_position,
    output logic [11:0]                o_radius,
    output logic [11:0]                o_position_echo,
    output logic                       o_valid_res,
    output logic                       o_strobe
);

    pre_pkg::t_len  r_len, n_len;
    logic           r_phase;
    logic           r_strobe;
    logic           r_ok;
    logic [11:0]    r_pos;

    logic           accept, load, read, room, ok;
    pre_pkg::t_len  base;
    pre_pkg::t_ext  n_pos;
    pre_pkg::t_load load_port;
    pre_pkg::t_pos  host_addr;
    pre_pkg::t_pos  rad_q;
    logic           core_busy;

    pre_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (load && i_last),
        .i_len       (r_len),
        .i_load      (load_port),
        .i_host_addr (host_addr),
        .o_rad_q     (rad_q),
        .o_busy      (core_busy)
    );

    always_comb begin
        accept = start && !busy;
        load   = accept && (i_cmd == pre_pkg::CMD_LOAD);
        read   = accept && (i_cmd == pre_pkg::CMD_READ);
        base   = r_phase ? '0 : r_len;
        room   = (base < pre_pkg::t_len'(pre_pkg::MAX_SYMBOLS));
        n_len  = room ? base + pre_pkg::t_len'(1) : base;

        load_port.we   = load && room;
        load_port.addr = base[pre_pkg::SYM_AW-1:0];
        load_port.sym  = i_symbol;

        n_pos = (pre_pkg::t_ext'(r_len) << 1) + pre_pkg::t_ext'(2);
        ok    = r_phase && (i_position != '0) && (pre_pkg::t_ext'(i_position) <= n_pos);
        host_addr = ok ? pre_pkg::t_pos'(i_position) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_phase  <= 1'b0;
            r_strobe <= 1'b0;
            r_ok     <= 1'b0;
        end else begin
            if (load) begin
                r_len   <= n_len;
                r_phase <= i_last;
            end
            r_strobe <= read;
            r_ok     <= read && ok;
        end
        if (read) begin
            r_pos <= i_position;
        end
    end

    assign busy            = core_busy;
    assign o_strobe        = r_strobe;
    assign o_valid_res     = r_ok;
    assign o_position_echo = r_pos;
    assign o_radius        = r_ok ? pre_pkg::t_field'(rad_q) : '0;

endmodule

// File: dv/tb_palindrome_radius_engine.sv
// Testbench for palindrome_radius_engine: symbol loads, radius reads, Manacher-based checking.
`timescale 1ns / 1ps

module tb_palindrome_radius_engine;

    typedef logic [pre_pkg::SYM_W-1:0] t_sym;

    typedef enum int {
        F_SMALL,
        F_FULL,
        F_MIRROR,
        F_EXTREME
    } t_flavor;

    typedef struct {
        pre_pkg::t_field radius;
        pre_pkg::t_field echo;
        logic            ok;
    } t_radius_word;

    class radius_checker;
        pre_pkg::t_word  interleaved[pre_pkg::STR_LEN+1];
        pre_pkg::t_field radii[pre_pkg::STR_LEN+1];
        int              symbol_count;
        bit              computed;
        t_radius_word    expected_radii[$];
        int              faults;

        function new();
            symbol_count = 0;
            computed     = 0;
            faults       = 0;
        endfunction

        function pre_pkg::t_word fetch_word(int idx, int n_pos);
            pre_pkg::t_word w;
            w.kind = pre_pkg::K_END;
            w.sym  = '0;
            if (idx >= 1 && idx <= n_pos) begin
                w = interleaved[idx];
            end
            return w;
        endfunction

        function void build_radii();
            int n_pos, r, mirror, a, b, ctr, reach;
            n_pos = 2 * symbol_count + 2;
            interleaved[1].kind = pre_pkg::K_SENT;
            interleaved[1].sym  = '0;
            interleaved[2].kind = pre_pkg::K_SEP;
            interleaved[2].sym  = '0;
            ctr   = 0;
            reach = 0;
            for (int i = 1; i <= n_pos; i++) begin
                r = 1;
                if (i < reach) begin
                    mirror = 2 * ctr - i;
                    a = (mirror == 0) ? 0 : int'(radii[mirror]);
                    b = int'(radii[ctr]) - (i - ctr);
                    r = (a < b) ? a : b;
                end
                while (r < i + 1 && r <= n_pos &&
                       fetch_word(i - r, n_pos) == fetch_word(i + r, n_pos)) begin
                    r++;
                end
                radii[i] = pre_pkg::t_field'(r);
                if (r + i > reach) begin
                    reach = r + i;
                    ctr   = i;
                end
            end
            computed = 1;
        endfunction

        function void note_word(logic cmd, t_sym sym, logic last, pre_pkg::t_field pos);
            t_radius_word want;
            int n_pos;
            if (cmd == pre_pkg::CMD_LOAD) begin
                if (computed) begin
                    symbol_count = 0;
                    computed     = 0;
                end
                if (symbol_count < pre_pkg::MAX_SYMBOLS) begin
                    interleaved[2*symbol_count+3].kind = pre_pkg::K_DATA;
                    interleaved[2*symbol_count+3].sym  = sym;
                    interleaved[2*symbol_count+4].kind = pre_pkg::K_SEP;
                    interleaved[2*symbol_count+4].sym  = '0;
                    symbol_count++;
                end
                if (last) begin
                    build_radii();
                end
            end else begin
                n_pos       = 2 * symbol_count + 2;
                want.ok     = computed && pos >= 1 && int'(pos) <= n_pos;
                want.radius = want.ok ? radii[pos] : '0;
                want.echo   = pos;
                expected_radii = {expected_radii, want};
            end
        endfunction

        function void record_fault(string what);
            faults++;
            if (faults <= 10) begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        function void check_radius(pre_pkg::t_field radius, pre_pkg::t_field echo, logic ok);
            t_radius_word want;
            if (expected_radii.size() == 0) begin
                record_fault($sformatf("unexpected result: radius %0d pos %0d valid %0b",
                                       radius, echo, ok));
                return;
            end
            want = expected_radii.pop_front();
            if (radius !== want.radius || echo !== want.echo || ok !== want.ok) begin
                record_fault($sformatf(
                    "mismatch: expected radius %0d pos %0d valid %0b, got %0d %0d %0b",
                    want.radius, want.echo, want.ok, radius, echo, ok));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cmd;
    t_sym               i_symbol;
    logic               i_last;
    logic [11:0]        i_position;
    logic [11:0]        o_radius;
    logic [11:0]        o_position_echo;
    logic               o_valid_res;
    logic               o_strobe;

    radius_checker sb;
    bit            quiet;
    int            words_sent;

    palindrome_radius_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_symbol        (i_symbol),
        .i_last          (i_last),
        .i_position      (i_position),
        .o_radius        (o_radius),
        .o_position_echo (o_position_echo),
        .o_valid_res     (o_valid_res),
        .o_strobe        (o_strobe)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_radius(o_radius, o_position_echo, o_valid_res);
        end
    end

    task automatic send_word(logic cmd, t_sym sym, logic last, pre_pkg::t_field pos);
        if (!quiet && $urandom_range(99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_symbol   <= sym;
        i_last     <= last;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(cmd, sym, last, pos);
        words_sent++;
    endtask

    task automatic load_symbol(t_sym sym, logic last);
        pre_pkg::t_field pos;
        pos = pre_pkg::t_field'($urandom_range(0, 2050));
        send_word(pre_pkg::CMD_LOAD, sym, last, pos);
    endtask

    task automatic read_at(pre_pkg::t_field pos);
        t_sym sym;
        sym = t_sym'($urandom_range(0, 1000000006));
        send_word(pre_pkg::CMD_READ, sym, 1'($urandom_range(1)), pos);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_radii.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_sequence(int n, t_flavor flavor, bit close);
        t_sym syms[$];
        t_sym s;
        for (int k = 0; k < n; k++) begin
            case (flavor)
                F_SMALL: s = t_sym'($urandom_range(0, 2));
                F_FULL:  s = t_sym'($urandom_range(0, 1000000006));
                F_MIRROR: begin
                    if (k < (n + 1) / 2) begin
                        s = ($urandom_range(1) == 0) ? t_sym'($urandom_range(0, 3))
                                                     : t_sym'($urandom_range(0, 1000000006));
                    end else begin
                        s = syms[n-1-k];
                    end
                end
                default: s = ($urandom_range(1) == 0) ? t_sym'(0) : t_sym'(1000000006);
            endcase
            syms = {syms, s};
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 5) begin
                read_at(pre_pkg::t_field'($urandom_range(0, 2050)));
            end
            load_symbol(syms[k], close && k == n - 1);
        end
    endtask

    task automatic read_radii(int count);
        pre_pkg::t_field pos;
        for (int c = 0; c < count; c++) begin
            if ($urandom_range(9) < 8) begin
                pos = pre_pkg::t_field'($urandom_range(1, 2 * sb.symbol_count + 2));
            end else begin
                pos = pre_pkg::t_field'($urandom_range(0, 2050));
            end
            read_at(pos);
        end
    endtask

    initial begin
        int round, n;
        sb         = new();
        quiet      = 1'b0;
        words_sent = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = pre_pkg::CMD_LOAD;
        i_symbol   = '0;
        i_last     = 1'b0;
        i_position = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: read before any load, zero symbol at end, extremes, new sequence
        read_at(12'd1);
        load_symbol(t_sym'(0), 1'b1);
        for (int p = 0; p <= 5; p++) begin
            read_at(pre_pkg::t_field'(p));
        end
        load_symbol(t_sym'(1000000006), 1'b0);
        read_at(12'd3);
        load_symbol(t_sym'(1000000006), 1'b1);
        read_at(12'd4);
        read_at(12'd5);
        read_at(12'd2050);
        load_symbol(t_sym'(715827882), 1'b0);
        load_symbol(t_sym'(357913941), 1'b0);
        load_symbol(t_sym'(715827882), 1'b1);
        read_at(12'd5);
        read_at(12'd6);
        read_at(12'd8);
        read_at(12'd9);

        round = 0;
        while (words_sent < 1900) begin
            round++;
            quiet = (round >= 20 && round < 28);
            n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
            load_sequence(n, t_flavor'($urandom_range(3)), $urandom_range(9) != 0);
            read_radii($urandom_range(2, 2 * n + 6));
            if (round == 15) begin
                wait_results_drained();
            end
            if (round == 30) begin
                // overflow: last mark lands on a dropped symbol
                load_sequence(pre_pkg::MAX_SYMBOLS + 2, F_SMALL, 1'b1);
                read_at(12'd1);
                read_at(12'd2049);
                read_at(12'd2050);
                read_at(12'd0);
                read_radii(30);
            end
        end

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("** palindrome_radius_engine: PASSED **");
        end else begin
            $display("** palindrome_radius_engine: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** palindrome_radius_engine: FAILED **");
        $finish;
    end

endmodule

// File: files.f
src/pre_pkg.sv
src/pre_word_cmp.sv
src/pre_core.sv
src/palindrome_radius_engine.sv
dv/tb_palindrome_radius_engine.sv
